// File: rtl/fkmg_pkg.sv
// Package for the frame keep mask generator.
// Holds mask sizing constants, the result mode codes, the sequencer states
// and the helper that builds a filled run of ones. No dependencies.
package fkmg_pkg;

  // Mask geometry.
  localparam int MAX_POSITIONS = 64;
  localparam int MaskW         = 64;
  localparam int PosIdxW       = $clog2(MAX_POSITIONS);

  // Field widths.
  localparam int RateW = 7;
  localparam int ModeW = 2;
  localparam int PosW  = 10;
  localparam int SumW  = 10;

  // Shared divider: one quotient bit per cycle.
  localparam int DivSteps = RateW;
  localparam int DivCntW  = $clog2(DivSteps);

  // Result mode codes.
  typedef enum logic [ModeW-1:0] {
    MODE_SPREAD = 2'd0,
    MODE_FILL   = 2'd1,
    MODE_EMPTY  = 2'd2
  } mode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PAIR,
    ST_SET,
    ST_CHECK
  } state_t;

  // Low n ones, saturated at the mask size.
  function automatic logic [MaskW-1:0] low_ones(input logic [RateW-1:0] n);
    logic [MaskW-1:0] res;
    res = '0;
    for (int i = 0; i < MaskW; i++) begin
      res[i] = (i < int'(n)) && (i < MAX_POSITIONS);
    end
    return res;
  endfunction

endpackage

// File: rtl/frame_keep_mask_generator.sv
// Top level of the frame keep mask generator: sequencer, shared divider and mask register.
// Depends on fkmg_pkg.
//
// Channel   Direction  Handshake                     Payload
// input     in         start high while busy low     in_source_rate, in_target_rate
// result    out        out_valid, one-cycle strobe   out_keep_mask, out_mask_mode
//
// Zero target, or target at or above source: the result strobes in the cycle after start.
// Spread pattern: each run pair takes up to two divisions through one shared restoring
// divider (none when the source is exactly twice the target), clips its runs in ST_PAIR,
// marks one kept slot per cycle in ST_SET, skips the dropped run, then checks in ST_CHECK.
// busy is high while the walk runs; reset (synchronous, active low) returns to idle.
// The receiver cannot stall: out_valid is high for exactly one cycle per result.
module frame_keep_mask_generator
  import fkmg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [RateW-1:0] in_source_rate,
  input  logic [RateW-1:0] in_target_rate,
  output logic             out_valid,
  output logic [MaskW-1:0] out_keep_mask,
  output logic [ModeW-1:0] out_mask_mode
);

  state_t state_r, state_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [MaskW-1:0]       out_mask_r, out_mask_nxt;
  logic [ModeW-1:0]       out_mode_r, out_mode_nxt;

  logic [RateW-1:0]       src_r, src_nxt;
  logic signed [SumW-1:0] s_r, s_nxt;
  logic [RateW-1:0]       t_r, t_nxt;
  logic [PosW-1:0]        pos_r, pos_nxt;
  logic [MaskW-1:0]       mask_r, mask_nxt;
  logic [RateW-1:0]       wk_r, wk_nxt;
  logic [RateW-1:0]       wd_r, wd_nxt;
  logic [RateW-1:0]       kc_r, kc_nxt;
  logic [RateW-1:0]       m_r, m_nxt;
  logic                   km0_r, km0_nxt;

  // Shared divider registers.
  logic [RateW-1:0]       quo_r, quo_nxt;
  logic [RateW-1:0]       rem_r, rem_nxt;
  logic [RateW-1:0]       dvs_r, dvs_nxt;
  logic [DivCntW-1:0]     dcnt_r, dcnt_nxt;
  logic                   dsel_r, dsel_nxt;

  // Divider step and run pair arithmetic.
  logic [RateW:0]         trial;
  logic [RateW+1:0]       diff;
  logic                   ge;
  logic [RateW-1:0]       qbit_res;
  logic [RateW-1:0]       k_val;
  logic [RateW-1:0]       t_after;
  logic signed [SumW-1:0] budget;
  logic [RateW-1:0]       m_val;
  logic                   s_eq_2t;
  logic                   s_le_0;
  logic                   s_gt_t;
  logic                   pos_done;

  assign trial    = {rem_r, quo_r[RateW-1]};
  assign diff     = {1'b0, trial} - {2'b00, dvs_r};
  assign ge       = ~diff[RateW+1];
  assign qbit_res = {quo_r[RateW-2:0], ge};

  assign k_val   = (wk_r < t_r) ? wk_r : t_r;
  assign t_after = t_r - k_val;
  assign budget  = s_r - $signed({{(SumW-RateW){1'b0}}, t_after})
                       + $signed({{(SumW-RateW){1'b0}}, k_val});
  assign m_val   = ($signed({{(SumW-RateW){1'b0}}, wd_r}) < budget) ? wd_r : budget[RateW-1:0];

  assign s_eq_2t  = s_r == $signed({{(SumW-RateW-1){1'b0}}, t_r, 1'b0});
  assign s_le_0   = s_r[SumW-1] || (s_r == '0);
  assign s_gt_t   = s_r > $signed({{(SumW-RateW){1'b0}}, t_r});
  assign pos_done = pos_r >= {{(PosW-RateW){1'b0}}, src_r};

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_mask_r <= out_mask_nxt;
    out_mode_r <= out_mode_nxt;
    src_r      <= src_nxt;
    s_r        <= s_nxt;
    t_r        <= t_nxt;
    pos_r      <= pos_nxt;
    mask_r     <= mask_nxt;
    wk_r       <= wk_nxt;
    wd_r       <= wd_nxt;
    kc_r       <= kc_nxt;
    m_r        <= m_nxt;
    km0_r      <= km0_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    dcnt_r     <= dcnt_nxt;
    dsel_r     <= dsel_nxt;
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_mask_nxt  = out_mask_r;
    out_mode_nxt  = out_mode_r;
    src_nxt       = src_r;
    s_nxt         = s_r;
    t_nxt         = t_r;
    pos_nxt       = pos_r;
    mask_nxt      = mask_r;
    wk_nxt        = wk_r;
    wd_nxt        = wd_r;
    kc_nxt        = kc_r;
    m_nxt         = m_r;
    km0_nxt       = km0_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    dcnt_nxt      = dcnt_r;
    dsel_nxt      = dsel_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          src_nxt = in_source_rate;
          s_nxt   = $signed({{(SumW-RateW){1'b0}}, in_source_rate});
          t_nxt   = in_target_rate;
          pos_nxt = '0;
          mask_nxt = '0;
          if (in_target_rate == '0) begin
            out_valid_nxt = 1'b1;
            out_mask_nxt  = '0;
            out_mode_nxt  = MODE_EMPTY;
          end else if (in_target_rate >= in_source_rate) begin
            // Target at or above source: a filled run of source ones.
            out_valid_nxt = 1'b1;
            out_mask_nxt  = low_ones(in_source_rate);
            out_mode_nxt  = MODE_FILL;
          end else if ({in_target_rate, 1'b0} == {1'b0, in_source_rate}) begin
            wk_nxt    = RateW'(1);
            wd_nxt    = RateW'(1);
            state_nxt = ST_PAIR;
          end else begin
            quo_nxt   = in_source_rate;
            rem_nxt   = '0;
            dvs_nxt   = in_source_rate - in_target_rate;
            dcnt_nxt  = '0;
            dsel_nxt  = 1'b0;
            state_nxt = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        // One restoring division step; the kept run first, then the dropped run.
        rem_nxt  = ge ? diff[RateW-1:0] : trial[RateW-1:0];
        quo_nxt  = qbit_res;
        dcnt_nxt = dcnt_r + DivCntW'(1);
        if (dcnt_r == DivCntW'(DivSteps - 1)) begin
          if (!dsel_r) begin
            wk_nxt   = qbit_res;
            quo_nxt  = s_r[RateW-1:0];
            rem_nxt  = '0;
            dvs_nxt  = t_r;
            dcnt_nxt = '0;
            dsel_nxt = 1'b1;
          end else begin
            wd_nxt    = qbit_res;
            state_nxt = ST_PAIR;
          end
        end
      end

      ST_PAIR: begin
        // Clip both runs and update the remaining counts.
        kc_nxt    = k_val;
        m_nxt     = m_val;
        km0_nxt   = (k_val == '0) && (m_val == '0);
        t_nxt     = t_after;
        s_nxt     = s_r - $signed({{(SumW-RateW){1'b0}}, k_val})
                        - $signed({{(SumW-RateW){1'b0}}, m_val});
        state_nxt = ST_SET;
      end

      ST_SET: begin
        // Mark one kept slot per cycle, then skip the dropped run.
        if (kc_r != '0) begin
          if (pos_r < PosW'(MAX_POSITIONS)) begin
            mask_nxt[pos_r[PosIdxW-1:0]] = 1'b1;
          end
          pos_nxt = pos_r + PosW'(1);
          kc_nxt  = kc_r - RateW'(1);
        end else begin
          pos_nxt   = pos_r + {{(PosW-RateW){1'b0}}, m_r};
          state_nxt = ST_CHECK;
        end
      end

      ST_CHECK: begin
        // Decide whether the walk goes on and how the next runs are found.
        if (km0_r || pos_done) begin
          state_nxt = ST_IDLE;
        end else if (s_eq_2t) begin
          if (s_le_0) begin
            state_nxt = ST_IDLE;
          end else begin
            wk_nxt    = RateW'(1);
            wd_nxt    = RateW'(1);
            state_nxt = ST_PAIR;
          end
        end else if ((t_r != '0) && s_gt_t) begin
          quo_nxt   = s_r[RateW-1:0];
          rem_nxt   = '0;
          dvs_nxt   = s_r[RateW-1:0] - t_r;
          dcnt_nxt  = '0;
          dsel_nxt  = 1'b0;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
        if (state_nxt == ST_IDLE) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = mask_r;
          out_mode_nxt  = MODE_SPREAD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Port drive.
  assign busy          = state_r != ST_IDLE;
  assign out_valid     = out_valid_r;
  assign out_keep_mask = out_mask_r;
  assign out_mask_mode = out_mode_r;

endmodule

// File: rtl/fkmg_checker.sv
// Port-level checker for the frame keep mask generator, bound to the top level.
// Depends on fkmg_pkg and frame_keep_mask_generator.
module fkmg_checker
  import fkmg_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [RateW-1:0] in_source_rate,
  input logic [RateW-1:0] in_target_rate,
  input logic             out_valid,
  input logic [MaskW-1:0] out_keep_mask,
  input logic [ModeW-1:0] out_mask_mode
);

  // An empty target always yields an empty mask.
  a_empty_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mask_mode == MODE_EMPTY) |-> (out_keep_mask == '0))
    else $error("empty-target result carries a nonzero mask");

  // A spread pattern always keeps slot zero.
  a_spread_bit0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mask_mode == MODE_SPREAD) |-> out_keep_mask[0])
    else $error("spread result does not keep slot zero");

  // A zero-target transaction answers in the next cycle.
  a_zero_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_target_rate == '0)
      |=> out_valid && (out_mask_mode == MODE_EMPTY))
    else $error("zero-target transaction not answered at once");

  // Target at or above source answers with a fill in the next cycle.
  a_fill_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_target_rate != '0) && (in_target_rate >= in_source_rate)
      |=> out_valid && (out_mask_mode == MODE_FILL))
    else $error("fill transaction not answered at once");

  // No result appears while a walk is still running.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    busy && $past(busy) |-> !out_valid)
    else $error("result strobe during a running walk");

endmodule

bind frame_keep_mask_generator fkmg_checker u_fkmg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_source_rate (in_source_rate),
  .in_target_rate (in_target_rate),
  .out_valid      (out_valid),
  .out_keep_mask  (out_keep_mask),
  .out_mask_mode  (out_mask_mode)
);

// File: verif/tb_frame_keep_mask_generator.sv
// Self-checking testbench for frame_keep_mask_generator: a predictor computes each
// keep mask and mode from the rate pair and a monitor compares every result strobe.
// Depends on fkmg_pkg and the frame_keep_mask_generator RTL.
`timescale 1ns / 100ps

module tb_frame_keep_mask_generator;
  import fkmg_pkg::*;

  // One rate pair to be sent to the block.
  typedef struct {
    logic [RateW-1:0] source_rate;
    logic [RateW-1:0] target_rate;
  } rate_pair_t;

  // One predicted result, with the rates that caused it for reporting.
  typedef struct {
    logic [MaskW-1:0] keep_mask;
    mode_t            mask_mode;
    logic [RateW-1:0] source_rate;
    logic [RateW-1:0] target_rate;
  } keep_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [RateW-1:0] in_source_rate = '0;
  logic [RateW-1:0] in_target_rate = '0;
  logic             out_valid;
  logic [MaskW-1:0] out_keep_mask;
  logic [ModeW-1:0] out_mask_mode;

  rate_pair_t   rate_pairs_q[$];
  keep_result_t keep_mask_expected_q[$];
  int           error_count = 0;
  int           burst_left = 1;
  int           gap_left = 0;

  frame_keep_mask_generator i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_source_rate(in_source_rate),
    .in_target_rate(in_target_rate),
    .out_valid     (out_valid),
    .out_keep_mask (out_keep_mask),
    .out_mask_mode (out_mask_mode)
  );

  always #5 clk = ~clk;

  // Low n ones, saturated at the mask width.
  function automatic logic [MaskW-1:0] fill_ones(input int n);
    if (n >= MaskW) begin
      return '1;
    end
    return (64'd1 << n) - 64'd1;
  endfunction

  // Walks alternating kept and dropped runs over the source slots.
  function automatic logic [MaskW-1:0] spread_keep_mask(input int src, input int tgt);
    logic [MaskW-1:0] mask;
    int s;
    int t;
    int pos;
    int run_keep;
    int run_drop;
    int k;
    int m;
    int budget;
    int old_s;
    bit done;
    mask = '0;
    s = src;
    t = tgt;
    pos = 0;
    done = 1'b0;
    if (t == s - t) begin
      run_keep = 1;
      run_drop = 1;
    end else begin
      run_keep = s / (s - t);
      run_drop = s / t;
    end
    while (!done) begin
      old_s = s;
      k = (run_keep < t) ? run_keep : t;
      if (k < 0) begin
        k = 0;
      end
      for (int j = 0; j < k; j++) begin
        if (pos + j < MAX_POSITIONS) begin
          mask[pos + j] = 1'b1;
        end
      end
      t = t - k;
      budget = old_s - t + k;
      m = (run_drop < budget) ? run_drop : budget;
      if (m < 0) begin
        m = 0;
      end
      pos = pos + k + m;
      s = s - k - m;
      if (k + m == 0) begin
        done = 1'b1;
      end else if (t == s - t) begin
        if (s <= 0) begin
          done = 1'b1;
        end else begin
          run_keep = 1;
          run_drop = 1;
        end
      end else if (t > 0 && s > t) begin
        run_keep = s / (s - t);
        run_drop = s / t;
      end else begin
        done = 1'b1;
      end
      if (!done && pos >= src) begin
        done = 1'b1;
      end
    end
    return mask;
  endfunction

  // Expected keep mask and mode for one rate pair.
  function automatic keep_result_t predict_keep_mask(input rate_pair_t pair);
    keep_result_t res;
    int src;
    int tgt;
    src = int'(pair.source_rate);
    tgt = int'(pair.target_rate);
    res.source_rate = pair.source_rate;
    res.target_rate = pair.target_rate;
    if (tgt == 0) begin
      res.keep_mask = '0;
      res.mask_mode = MODE_EMPTY;
    end else if (tgt >= src) begin
      res.keep_mask = fill_ones(src);
      res.mask_mode = MODE_FILL;
    end else begin
      res.keep_mask = spread_keep_mask(src, tgt);
      res.mask_mode = MODE_SPREAD;
    end
    return res;
  endfunction

  function automatic rate_pair_t make_pair(input int src, input int tgt);
    rate_pair_t pair;
    pair.source_rate = RateW'(src);
    pair.target_rate = RateW'(tgt);
    return pair;
  endfunction

  // Driver: presents queued rate pairs in bursts with random gaps between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        keep_mask_expected_q.push_back(predict_keep_mask(rate_pairs_q[0]));
        void'(rate_pairs_q.pop_front());
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6, 7: gap_left = $urandom_range(1, 6);
            8:          gap_left = $urandom_range(10, 60);
            default:    gap_left = $urandom_range(200, 1500);
          endcase
        end
      end
      // A transaction still waiting keeps its fields; otherwise pick what comes next.
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (rate_pairs_q.size() != 0) begin
          start          <= 1'b1;
          in_source_rate <= rate_pairs_q[0].source_rate;
          in_target_rate <= rate_pairs_q[0].target_rate;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (keep_mask_expected_q.size() == 0) begin
        error_count++;
        if (error_count < 40) begin
          $display("%0t: unexpected result, expected none, actual mask %h mode %0d",
                   $time, out_keep_mask, out_mask_mode);
        end
      end else begin
        if (out_keep_mask !== keep_mask_expected_q[0].keep_mask) begin
          error_count++;
          if (error_count < 40) begin
            $display("%0t: keep_mask for src %0d tgt %0d, expected %h, actual %h",
                     $time, keep_mask_expected_q[0].source_rate,
                     keep_mask_expected_q[0].target_rate,
                     keep_mask_expected_q[0].keep_mask, out_keep_mask);
          end
        end
        if (out_mask_mode !== keep_mask_expected_q[0].mask_mode) begin
          error_count++;
          if (error_count < 40) begin
            $display("%0t: mask_mode for src %0d tgt %0d, expected %0d, actual %0d",
                     $time, keep_mask_expected_q[0].source_rate,
                     keep_mask_expected_q[0].target_rate,
                     keep_mask_expected_q[0].mask_mode, out_mask_mode);
          end
        end
        void'(keep_mask_expected_q.pop_front());
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int src;
    int tgt;
    // Directed corners: empty target, fills, exact halves and dense or sparse spreads.
    rate_pairs_q.push_back(make_pair(0, 0));
    rate_pairs_q.push_back(make_pair(5, 0));
    rate_pairs_q.push_back(make_pair(64, 0));
    rate_pairs_q.push_back(make_pair(0, 5));
    rate_pairs_q.push_back(make_pair(0, 64));
    rate_pairs_q.push_back(make_pair(10, 20));
    rate_pairs_q.push_back(make_pair(63, 64));
    rate_pairs_q.push_back(make_pair(1, 1));
    rate_pairs_q.push_back(make_pair(40, 40));
    rate_pairs_q.push_back(make_pair(64, 64));
    rate_pairs_q.push_back(make_pair(2, 1));
    rate_pairs_q.push_back(make_pair(64, 32));
    rate_pairs_q.push_back(make_pair(64, 1));
    rate_pairs_q.push_back(make_pair(64, 63));
    rate_pairs_q.push_back(make_pair(64, 2));
    rate_pairs_q.push_back(make_pair(64, 33));
    rate_pairs_q.push_back(make_pair(64, 31));
    rate_pairs_q.push_back(make_pair(7, 3));
    rate_pairs_q.push_back(make_pair(13, 5));
    rate_pairs_q.push_back(make_pair(5, 4));
    rate_pairs_q.push_back(make_pair(17, 16));
    rate_pairs_q.push_back(make_pair(60, 25));
    rate_pairs_q.push_back(make_pair(3, 1));
    // Random part: mostly spread patterns, the rest the short paths.
    for (int i = 0; i < 270; i++) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          src = $urandom_range(0, 64);
          tgt = 0;
        end
        2, 3: begin
          src = $urandom_range(0, 63);
          tgt = $urandom_range(src + 1, 64);
        end
        4: begin
          src = $urandom_range(1, 64);
          tgt = src;
        end
        default: begin
          src = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(2, 64);
          tgt = $urandom_range(1, src - 1);
        end
      endcase
      rate_pairs_q.push_back(make_pair(src, tgt));
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (rate_pairs_q.size() != 0 || keep_mask_expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);
    if (keep_mask_expected_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d results still outstanding", $time, keep_mask_expected_q.size());
    end
    if (error_count == 0) begin
      $display("tb_frame_keep_mask_generator: done, clean");
    end else begin
      $display("tb_frame_keep_mask_generator: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #40_000_000;
    $display("tb_frame_keep_mask_generator: done, errors");
    $finish;
  end

endmodule

// File: sim.f
rtl/fkmg_pkg.sv
rtl/frame_keep_mask_generator.sv
rtl/fkmg_checker.sv
verif/tb_frame_keep_mask_generator.sv
